### design/bpa_pkg.sv
// shared types and constants of the bitmap page allocator
package bpa_pkg;

	// fixed field widths
	localparam int CNT_W     = 13;
	localparam int FRAME_W   = 52;
	localparam int CFG_IDX_W = 8;
	localparam int TDATA_W   = 72;

	// default number of pages in the used map
	localparam int MAX_PAGES_DEF = 4096;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEG_BASE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SEG_PAGES = CFG_IDX_W'(1);

	// reset values of the registers
	localparam logic [FRAME_W-1:0] SEG_BASE_RST = FRAME_W'(256);

	// operation codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_PREP,
		ST_SCAN,
		ST_MARK,
		ST_FREE,
		ST_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic decide;
		logic prep;
		logic scan;
		logic mark;
		logic free_walk;
		logic clear;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_free;
		logic alloc_go;
		logic free_go;
		logic hit;
		logic scan_miss;
		logic mark_done;
		logic free_done;
		logic clear_done;
		logic reload;
		logic out_busy;
	} sts_t;

endpackage

### design/bitmap_page_allocator_unit.sv
// Bitmap first-fit page allocator for one segment of pages.
// Allocate: a first-fit scan of the used map, one page a cycle through the map's read port,
// then a write that marks each allocated page; no scan if the count is zero or too few are free.
// Free: clears each used page in the range clamped at the segment end; no walk outside the segment or for a zero count.
// Reset and every segment_pages write start a clearing pass over all min(MAX_PAGES, 8192)
// entries of the used map, during which no request is taken.
module bitmap_page_allocator_unit
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAME_W-1:0]   cfg_data,
	// request stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,   // page_count[12:0], free_frame[64:13], zero pad
	input  logic                 s_tuser,   // func
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,   // start_frame[51:0], free_pages[64:52], zero pad
	output logic                 m_tuser    // ok
);

	cmd_t cmd;
	sts_t sts;

	// control
	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	bpa_dp #(
		.MAX_PAGES (MAX_PAGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

### design/bpa_ram.sv
// generic simple dual-port ram with registered read
module bpa_ram
#(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
)
(
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/bpa_ctrl.sv
// controller state machine of the bitmap page allocator
module bpa_ctrl
	import bpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	// state register, reset starts a clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.is_free) state_nxt = ST_PREP;
				else if (sts.alloc_go) state_nxt = ST_SCAN;
				else state_nxt = ST_RESULT;
			end
			ST_PREP: begin
				if (sts.free_go) state_nxt = ST_FREE;
				else state_nxt = ST_RESULT;
			end
			ST_SCAN: begin
				if (sts.hit) state_nxt = ST_MARK;
				else if (sts.scan_miss) state_nxt = ST_RESULT;
			end
			ST_MARK: begin
				if (sts.mark_done) state_nxt = ST_RESULT;
			end
			ST_FREE: begin
				if (sts.free_done) state_nxt = ST_RESULT;
			end
			ST_RESULT: begin
				if (!sts.out_busy) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
		// a segment reload restarts the clearing pass
		if (sts.reload) state_nxt = ST_CLEAR;
	end

	// outputs
	always_comb begin
		cmd       = '0;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_CLEAR:  cmd.clear = 1'b1;
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_DECIDE: cmd.decide    = 1'b1;
			ST_PREP:   cmd.prep      = 1'b1;
			ST_SCAN:   cmd.scan      = 1'b1;
			ST_MARK:   cmd.mark      = 1'b1;
			ST_FREE:   cmd.free_walk = 1'b1;
			ST_RESULT: cmd.load_out  = !sts.out_busy;
			default:   cmd           = '0;
		endcase
	end

endmodule

### design/bpa_dp.sv
// datapath of the bitmap page allocator: used map, counters, registers
module bpa_dp
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAME_W-1:0]   cfg_data,
	// request payload
	input  logic [TDATA_W-1:0]   s_tdata,
	input  logic                 s_tuser,
	// result
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,
	output logic                 m_tuser,
	// control
	input  cmd_t                 cmd,
	output sts_t                 sts
);

	// only pages below 2^CNT_W can ever be addressed
	localparam int MEM_DEPTH = (MAX_PAGES < (1 << CNT_W)) ? MAX_PAGES : (1 << CNT_W);
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam logic [CNT_W-1:0] PAGE_CAP =
		(MAX_PAGES >= (1 << CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(MAX_PAGES);
	localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);

	logic [FRAME_W-1:0] base_q;
	logic [CNT_W-1:0]   eff_q;
	logic [CNT_W-1:0]   free_cnt_q;
	logic [AW-1:0]      clr_q;

	logic               func_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FRAME_W-1:0] frame_q;
	logic               in_seg_q;
	logic [CNT_W-1:0]   pos_q;

	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   lim_q;
	logic               vld_s1;
	logic [CNT_W-1:0]   chk_idx_s1;
	logic [CNT_W-1:0]   run_q;
	logic [CNT_W-1:0]   mark_idx_q;
	logic [CNT_W-1:0]   mark_left_q;
	logic [CNT_W-1:0]   first_q;
	logic               res_ok_q;
	logic               res_alloc_q;

	logic               out_vld_q;
	logic               out_ok_q;
	logic [FRAME_W-1:0] out_start_q;
	logic [CNT_W-1:0]   out_free_q;

	logic               cfg_wr;
	logic               reload;
	logic [CNT_W-1:0]   new_pages;
	logic [CNT_W-1:0]   new_eff;
	logic [FRAME_W-1:0] diff;
	logic               in_seg;
	logic [CNT_W:0]     end_sum;
	logic [CNT_W-1:0]   end_clamp;
	logic               issue;
	logic               used;
	logic               chk_last;
	logic               hit;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic               ram_wdata;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign reload    = cfg_wr && (cfg_index == REG_SEG_PAGES);
	assign new_pages = cfg_data[CNT_W-1:0];
	assign new_eff   = (new_pages > PAGE_CAP) ? PAGE_CAP : new_pages;

	// segment registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= SEG_BASE_RST;
			eff_q  <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == REG_SEG_BASE) base_q <= cfg_data;
			if (reload) eff_q <= new_eff;
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (reload) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// request registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q  <= s_tuser;
			cnt_q   <= s_tdata[CNT_W-1:0];
			frame_q <= s_tdata[CNT_W+FRAME_W-1:CNT_W];
		end
	end

	// segment membership of a free request
	assign diff   = frame_q - base_q;
	assign in_seg = (frame_q >= base_q) && (diff < FRAME_W'(eff_q));

	// clamped end of the range to free
	assign end_sum   = {1'b0, pos_q} + {1'b0, cnt_q};
	assign end_clamp = (end_sum > {1'b0, eff_q}) ? eff_q : end_sum[CNT_W-1:0];

	// read issue and check of the used map
	assign issue    = (cmd.scan || cmd.free_walk) && (idx_q < lim_q) && !hit;
	assign chk_last = ({1'b0, chk_idx_s1} + 1'b1) == {1'b0, lim_q};
	assign hit      = cmd.scan && vld_s1 && !used && ((run_q + 1'b1) == cnt_q);

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) chk_idx_s1 <= idx_q;
		if (cmd.decide) begin
			in_seg_q    <= in_seg;
			pos_q       <= diff[CNT_W-1:0];
			idx_q       <= '0;
			lim_q       <= eff_q;
			run_q       <= '0;
			res_ok_q    <= (func_q == FUNC_FREE) && in_seg;
			res_alloc_q <= 1'b0;
		end else if (cmd.prep) begin
			idx_q <= pos_q;
			lim_q <= end_clamp;
		end else begin
			if (issue) idx_q <= idx_q + 1'b1;
			if (cmd.scan && vld_s1) run_q <= used ? '0 : run_q + 1'b1;
			if (hit) begin
				mark_idx_q  <= chk_idx_s1;
				mark_left_q <= cnt_q;
				first_q     <= chk_idx_s1 + 1'b1 - cnt_q;
				res_ok_q    <= 1'b1;
				res_alloc_q <= 1'b1;
			end
			if (cmd.mark) begin
				mark_idx_q  <= mark_idx_q - 1'b1;
				mark_left_q <= mark_left_q - 1'b1;
			end
		end
	end

	// free page counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_cnt_q <= '0;
		end else if (reload) begin
			free_cnt_q <= new_eff;
		end else if (hit) begin
			free_cnt_q <= free_cnt_q - cnt_q;
		end else if (cmd.free_walk && vld_s1 && used) begin
			free_cnt_q <= free_cnt_q + 1'b1;
		end
	end

	// used map write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 1'b0;
		priority if (cmd.clear) begin
			ram_we = 1'b1;
		end else if (cmd.mark) begin
			ram_we    = 1'b1;
			ram_waddr = mark_idx_q[AW-1:0];
			ram_wdata = 1'b1;
		end else if (cmd.free_walk) begin
			ram_we    = vld_s1;
			ram_waddr = chk_idx_s1[AW-1:0];
		end
	end

	bpa_ram #(
		.WIDTH (1),
		.DEPTH (MEM_DEPTH)
	) u_used_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (idx_q[AW-1:0]),
		.rdata (used)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_ok_q    <= res_ok_q;
			out_start_q <= res_alloc_q ? base_q + FRAME_W'(first_q) : '0;
			out_free_q  <= free_cnt_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_ok_q;
	assign m_tdata  = {{(TDATA_W-FRAME_W-CNT_W){1'b0}}, out_free_q, out_start_q};

	// status to the controller
	always_comb begin
		sts            = '0;
		sts.is_free    = (func_q == FUNC_FREE);
		sts.alloc_go   = (cnt_q != '0) && (free_cnt_q >= cnt_q) && (eff_q != '0);
		sts.free_go    = in_seg_q && (cnt_q != '0);
		sts.hit        = hit;
		sts.scan_miss  = cmd.scan && vld_s1 && chk_last && !hit;
		sts.mark_done  = (mark_left_q == CNT_W'(1));
		sts.free_done  = vld_s1 && chk_last;
		sts.clear_done = (clr_q == CLR_LAST);
		sts.reload     = reload;
		sts.out_busy   = out_vld_q && !m_tready;
	end

endmodule

### tb/bpa_checker.sv
// checker for the page allocator: tracks the used map and compares every result
module bpa_checker
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAME_W-1:0]   cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,   // page_count[12:0], free_frame[64:13], zero pad
	input  logic                 s_tuser,   // func
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [TDATA_W-1:0]   m_tdata,   // start_frame[51:0], free_pages[64:52], zero pad
	input  logic                 m_tuser,   // ok
	output int                   mismatches,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_AW = $clog2(MAX_PAGES);

	typedef struct packed {
		logic               ok;
		logic [FRAME_W-1:0] start_frame;
		logic [CNT_W-1:0]   free_pages;
	} page_result_t;

	// shadow copy of the allocator state
	logic [MAX_PAGES-1:0] used_map;
	logic [CNT_W-1:0]     free_cnt;
	logic [FRAME_W-1:0]   seg_base;
	logic [CNT_W-1:0]     seg_pages;
	page_result_t         pending_results[$];

	initial mismatches = 0;

	// pages that exist in the used map for the current segment size
	function automatic int live_pages();
		return (int'(seg_pages) > MAX_PAGES) ? MAX_PAGES : int'(seg_pages);
	endfunction

	task automatic flag(input string what);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t: mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		page_result_t       want;
		page_result_t       r;
		int                 pages;
		int                 run;
		int                 first;
		int                 pos;
		int                 stop;
		logic               func;
		logic [CNT_W-1:0]   cnt;
		logic [FRAME_W-1:0] frame;

		if (!arst_n) begin
			used_map = '0;
			free_cnt = '0;
			seg_base = SEG_BASE_RST;
			seg_pages = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			// a result always belongs to an earlier request, so check it first
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					flag("result with no request waiting");
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.ok)
						flag($sformatf("ok got %0h want %0h", m_tuser, want.ok));
					if (m_tdata[FRAME_W-1:0] !== want.start_frame)
						flag($sformatf("start_frame got %0h want %0h",
							m_tdata[FRAME_W-1:0], want.start_frame));
					if (m_tdata[FRAME_W +: CNT_W] !== want.free_pages)
						flag($sformatf("free_pages got %0d want %0d",
							m_tdata[FRAME_W +: CNT_W], want.free_pages));
				end
			end

			// register writes; a page count write reloads the segment
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SEG_BASE) begin
					seg_base = cfg_data;
				end else if (cfg_index == REG_SEG_PAGES) begin
					seg_pages = cfg_data[CNT_W-1:0];
					used_map = '0;
					free_cnt = CNT_W'(live_pages());
				end
			end

			// predict the result of an accepted request
			if (s_tvalid && s_tready) begin
				func = s_tuser;
				cnt = s_tdata[CNT_W-1:0];
				frame = s_tdata[CNT_W +: FRAME_W];
				pages = live_pages();
				r = '0;
				if (func == FUNC_ALLOC) begin
					// first fit over the used map
					if (cnt != '0 && free_cnt >= cnt) begin
						run = 0;
						for (int p = 0; p < pages; p++) begin
							if (used_map[MAP_AW'(p)]) begin
								run = 0;
							end else begin
								run++;
								if (run == int'(cnt)) begin
									first = p + 1 - int'(cnt);
									for (int k = first; k <= p; k++)
										used_map[MAP_AW'(k)] = 1'b1;
									free_cnt = free_cnt - cnt;
									r.ok = 1'b1;
									r.start_frame = seg_base + FRAME_W'(first);
									break;
								end
							end
						end
					end
				end else if (frame >= seg_base && (frame - seg_base) < FRAME_W'(pages)) begin
					// free walk, clamped at the segment end
					pos = int'(frame - seg_base);
					stop = pos + int'(cnt);
					if (stop > pages)
						stop = pages;
					for (int k = pos; k < stop; k++) begin
						if (used_map[MAP_AW'(k)]) begin
							used_map[MAP_AW'(k)] = 1'b0;
							free_cnt = free_cnt + 1'b1;
						end
					end
					r.ok = 1'b1;
				end
				r.free_pages = free_cnt;
				pending_results.push_back(r);
			end

			outstanding <= pending_results.size();
		end
	end

endmodule

### tb/tb.sv
// top of the page allocator testbench: clock, reset, stimulus and verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bpa_pkg::*;

	// write to an index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(2);
	localparam logic [FRAME_W-1:0]   FRAME_TOP = '1;
	localparam logic [CNT_W-1:0]     CNT_TOP = '1;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FRAME_W-1:0]   cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata;   // page_count[12:0], free_frame[64:13], zero pad
	logic                 s_tuser;   // func
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_W-1:0]   m_tdata;   // start_frame[51:0], free_pages[64:52], zero pad
	logic                 m_tuser;   // ok

	int mismatches;
	int outstanding;
	bit calm;
	logic [FRAME_W-1:0] cur_base;
	int cur_pages;

	bitmap_page_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	bpa_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("bitmap_page_allocator_unit verification failed");
		$finish;
	end

	// result side: random stall before each result, none while calm
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic logic [FRAME_W-1:0] rand_frame();
		return FRAME_W'({$urandom(), $urandom()});
	endfunction

	// page count write with random junk above the count bits
	function automatic logic [FRAME_W-1:0] pages_word(input int n);
		return (rand_frame() & ~FRAME_W'(CNT_TOP)) | FRAME_W'(n);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_segment(input logic [FRAME_W-1:0] base, input int n);
		write_reg(REG_SEG_BASE, base);
		write_reg(REG_SEG_PAGES, pages_word(n));
		cur_base = base;
		cur_pages = (n > MAX_PAGES_DEF) ? MAX_PAGES_DEF : n;
	endtask

	// one request, after a random gap unless calm
	task automatic request(input logic func, input logic [CNT_W-1:0] cnt,
		input logic [FRAME_W-1:0] frame);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= TDATA_W'({frame, cnt});
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic alloc(input logic [CNT_W-1:0] cnt);
		request(FUNC_ALLOC, cnt, rand_frame());
	endtask

	// hold the request side until every result is back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// mostly well-formed allocs and frees inside the segment, some noise
	task automatic random_burst(input int n);
		int pick;
		int top;
		logic [FRAME_W-1:0] frame;
		top = (cur_pages > 4) ? cur_pages / 4 : 1;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				alloc(CNT_W'($urandom_range(1, top)));
			end else if (pick < 80) begin
				frame = cur_base + FRAME_W'((cur_pages > 0) ? $urandom_range(0, cur_pages - 1) : 0);
				request(FUNC_FREE, CNT_W'($urandom_range(1, 8)), frame);
			end else begin
				case ($urandom_range(0, 3))
					0: frame = cur_base - 1'b1;
					1: frame = cur_base + FRAME_W'(cur_pages);
					default: frame = rand_frame();
				endcase
				request(1'($urandom), CNT_W'($urandom_range(0, 8191)), frame);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		calm = 1'b0;
		cur_base = SEG_BASE_RST;
		cur_pages = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty segment after reset
		alloc(CNT_W'(1));
		request(FUNC_FREE, CNT_W'(1), SEG_BASE_RST);
		settle();

		// small segment at the reset base: fit, exhaustion, frees, fragmentation
		set_segment(SEG_BASE_RST, 16);
		alloc(CNT_W'(0));
		alloc(CNT_W'(1));
		alloc(CNT_W'(3));
		alloc(CNT_W'(17));
		alloc(CNT_W'(12));
		request(FUNC_FREE, CNT_W'(2), cur_base + 1);
		request(FUNC_FREE, CNT_W'(2), cur_base + 1);
		request(FUNC_FREE, CNT_W'(1), cur_base - 1);
		request(FUNC_FREE, CNT_W'(1), cur_base + 16);
		request(FUNC_FREE, CNT_TOP, cur_base + 14);
		request(FUNC_FREE, CNT_W'(0), cur_base + 2);
		alloc(CNT_W'(2));
		request(FUNC_FREE, CNT_W'(4096), FRAME_TOP);
		alloc(CNT_TOP);
		settle();

		// segment at the top of the frame space, start frame wraps
		set_segment(FRAME_TOP - 3, 8);
		alloc(CNT_W'(4));
		alloc(CNT_W'(4));
		request(FUNC_FREE, CNT_W'(1), FRAME_TOP);
		request(FUNC_FREE, CNT_W'(1), '0);
		alloc(CNT_W'(1));
		settle();

		// base write alone keeps the map; unknown index does nothing
		write_reg(REG_NONE, rand_frame());
		write_reg(REG_SEG_BASE, '0);
		cur_base = '0;
		request(FUNC_FREE, CNT_W'(2), FRAME_W'(2));
		alloc(CNT_W'(2));
		settle();

		// oversize and full-size segments
		set_segment(rand_frame(), 8191);
		alloc(CNT_W'(4096));
		request(FUNC_FREE, CNT_TOP, cur_base);
		settle();
		set_segment(rand_frame(), 4096);
		alloc(CNT_W'(1));
		settle();

		// random phases over several segment settings
		set_segment(rand_frame(), 8);
		random_burst(30);
		settle();
		calm = 1'b1;
		set_segment('0, 1);
		random_burst(15);
		settle();
		calm = 1'b0;
		set_segment(FRAME_TOP - 20, 32);
		random_burst(35);
		settle();
		set_segment(rand_frame(), 100);
		random_burst(40);
		settle();
		set_segment(rand_frame(), 0);
		random_burst(10);
		settle();

		repeat (50) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("bitmap_page_allocator_unit verification clean");
		end else begin
			$display("bitmap_page_allocator_unit verification failed");
		end
		$finish;
	end

endmodule
